@@ src/mlcd_pkg.sv @@
`default_nettype none

package mlcd_pkg;

   // frame geometry
   localparam int FRAME_BYTES  = 35;
   localparam int DIGIT_COUNT  = 6;
   localparam int STORE_DEPTH  = (FRAME_BYTES - 1) / 2;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int INDEX_W      = 6;
   localparam int SEG_ENTRIES  = 15;

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(FRAME_BYTES - 1);

   // byte framing codes
   localparam logic [1:0] START_CODE = 2'd1;
   localparam logic [1:0] STOP_CODE  = 2'd3;

   // digit code shown for an unlit or unknown segment pattern
   localparam logic [3:0] CODE_BLANK = 4'd15;

   // seven-segment patterns, indexed by digit code
   localparam logic [6:0] SEG_TABLE [SEG_ENTRIES] = '{
      7'h7D, 7'h05, 7'h5B, 7'h1F, 7'h27,
      7'h3E, 7'h7E, 7'h15, 7'h7F, 7'h3F,
      7'h7A, 7'h68, 7'h46, 7'h42, 7'h02
   };

   typedef enum logic [2:0] {
      PREFIX_NONE  = 3'd0,
      PREFIX_NANO  = 3'd1,
      PREFIX_MICRO = 3'd2,
      PREFIX_MILLI = 3'd3,
      PREFIX_KILO  = 3'd4,
      PREFIX_MEGA  = 3'd5
   } prefix_type;

   typedef enum logic [2:0] {
      UNIT_VOLT    = 3'd0,
      UNIT_HERTZ   = 3'd1,
      UNIT_OHM     = 3'd2,
      UNIT_FARAD   = 3'd3,
      UNIT_AMP     = 3'd4,
      UNIT_DBM     = 3'd5,
      UNIT_PERCENT = 3'd6
   } unit_type;

   typedef enum logic [1:0] {
      COUPLING_NONE  = 2'd0,
      COUPLING_DC    = 2'd1,
      COUPLING_AC    = 2'd2,
      COUPLING_ACDC  = 2'd3
   } coupling_type;

   typedef enum logic [2:0] {
      MOD_NONE  = 3'd0,
      MOD_MIN   = 3'd1,
      MOD_MAX   = 3'd2,
      MOD_PP    = 3'd3,
      MOD_DELTA = 3'd4
   } modifier_type;

   typedef logic [7:0] store_type [STORE_DEPTH];

   // decoded display, handed from the decoder to the result register
   typedef struct packed {
      logic [4*DIGIT_COUNT-1:0] digit_codes;
      logic [DIGIT_COUNT-2:0]   point_flags;
      logic                     negative;
      prefix_type               prefix;
      unit_type                 unit;
      coupling_type             coupling;
      modifier_type             modifier;
   } display_type;

   // segment pattern to digit code
   function automatic logic [3:0] seg_code(input logic [6:0] seg);
      logic [3:0] code;
      code = CODE_BLANK;
      for (int i = SEG_ENTRIES - 1; i >= 0; i--) begin
         if (SEG_TABLE[i] == seg) begin
            code = 4'(i);
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

@@ src/mlcd_decode.sv @@
`default_nettype none

module mlcd_decode
   import mlcd_pkg::*;
(
   input  store_type   store,
   output display_type display
);

   logic [7:0] sw;
   logic [3:0] sw_hi;
   logic [3:0] sw_lo;
   logic       dbm;
   logic       pct;
   logic [7:0] f1;
   logic [7:0] f2;
   logic [7:0] f15;
   logic [7:0] f16;

   assign sw    = ~store[0];
   assign sw_hi = sw[7:4];
   assign sw_lo = sw[3:0];
   assign f1    = store[1];
   assign f2    = store[2];
   assign f15   = store[15];
   assign f16   = store[16];
   assign dbm   = f1[0];
   assign pct   = f15[3];

   always_comb begin
      // digits, points and sign
      display.digit_codes = '0;
      display.point_flags = '0;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         display.digit_codes[4*(DIGIT_COUNT-1-d) +: 4] = seg_code(store[3+d][6:0]);
      end
      for (int d = 1; d < DIGIT_COUNT; d++) begin
         display.point_flags[d-1] = store[3+d][7];
      end
      display.negative = store[3][7];

      // range prefix, largest prefix wins; none in dBm or percent mode
      priority if (dbm || pct) display.prefix = PREFIX_NONE;
      else if (f1[7])          display.prefix = PREFIX_MEGA;
      else if (f1[6])          display.prefix = PREFIX_KILO;
      else if (f1[1])          display.prefix = PREFIX_MILLI;
      else if (f1[2])          display.prefix = PREFIX_MICRO;
      else if (f2[6])          display.prefix = PREFIX_NANO;
      else                     display.prefix = PREFIX_NONE;

      // unit: dBm or percent flag first, else from the switch position, top set bit of the inverted byte
      priority if (dbm)                display.unit = UNIT_DBM;
      else if (pct)                    display.unit = UNIT_PERCENT;
      else if (sw_hi[3] || sw_hi[2])   display.unit = UNIT_VOLT;
      else if (sw_hi[1])               display.unit = UNIT_HERTZ;
      else if (sw_hi[0])               display.unit = UNIT_VOLT;
      else if (sw_lo[3] || sw_lo[2])   display.unit = UNIT_AMP;
      else if (sw_lo[1])               display.unit = UNIT_FARAD;
      else if (sw_lo[0])               display.unit = UNIT_OHM;
      else                             display.unit = UNIT_VOLT;

      // coupling
      unique case ({f2[3], f2[2]})
         2'b11:   display.coupling = COUPLING_ACDC;
         2'b10:   display.coupling = COUPLING_AC;
         2'b01:   display.coupling = COUPLING_DC;
         default: display.coupling = COUPLING_NONE;
      endcase

      // modifier, priority delta, peak-peak, max, min
      priority if (f16[7]) display.modifier = MOD_DELTA;
      else if (f16[4])     display.modifier = MOD_PP;
      else if (f16[6])     display.modifier = MOD_MAX;
      else if (f15[1])     display.modifier = MOD_MIN;
      else                 display.modifier = MOD_NONE;
   end

endmodule

`default_nettype wire

@@ src/meter_lcd_frame_decoder.sv @@
// Meter LCD frame decoder.
// The req channel takes the meter's received bytes one per transfer: tdata
// carries the raw byte, tuser marks the first byte of a frame. Each frame has
// 35 bytes; a frame_start in mid-frame drops the partial frame.
// After the last byte of a frame one transfer leaves on the rsp channel:
// tuser is 1 for a decoded display, 0 for a framing failure, in which case
// tdata holds only the index of the first badly framed byte.
// Throughput: one byte per cycle while req_tready is high. The last byte
// taken completes the frame store and sets the frame complete flag; the
// decoded frame then goes into the result register, once it is free.
// When the receiver stalls the result holds in the result register; bytes
// are still taken until a second finished frame would need that register,
// which cannot happen within one frame time, so req stalls only when a
// result is held longer than that.
// Reset (synchronous, active high) clears the byte count, error tracking
// and both valid flags; the frame store needs no clearing since every entry
// is rewritten in each frame before it is decoded.
`default_nettype none

module meter_lcd_frame_decoder
   import mlcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] raw_byte
   input  wire logic [0:0]  req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [5:0] bad_byte_index, [29:6] digit_codes,
                                         // [34:30] point_flags, [35] negative,
                                         // [38:36] prefix, [41:39] unit,
                                         // [43:42] coupling, [46:44] modifier, [47] zero
   output logic [0:0]       rsp_tuser    // [0] frame_ok
);

   logic [INDEX_W-1:0] count_ff, count_in;
   logic               error_ff, error_in;
   logic [INDEX_W-1:0] first_bad_ff, first_bad_in;
   logic [3:0]         pending_ff, pending_in;
   store_type          store_ff;
   logic               done_ff, done_in;
   logic               fail_ff, fail_in;
   logic [INDEX_W-1:0] bad_ff, bad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff;
   logic [INDEX_W-1:0] rsp_bad_ff;
   display_type        rsp_disp_ff;

   logic               req_fire;
   logic               out_load;
   logic [INDEX_W-1:0] idx;
   logic               is_first;
   logic               is_last;
   logic               good;
   logic [3:0]         nib;
   logic               err_prior;
   logic [INDEX_W-1:0] bad_prior;
   logic               store_we;
   logic [STORE_AW-1:0] store_addr;
   display_type        display;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !done_ff || out_load;
   assign req_fire   = req_tvalid && req_tready;

   // byte position and framing check
   assign idx        = req_tuser[0] ? '0 : count_ff;
   assign is_first   = (idx == '0);
   assign is_last    = (idx == LAST_INDEX);
   assign good       = (req_tdata[1:0] == START_CODE) && (req_tdata[7:6] == STOP_CODE);
   assign nib        = req_tdata[5:2];
   assign err_prior  = is_first ? 1'b0 : error_ff;
   assign bad_prior  = is_first ? '0 : first_bad_ff;
   assign store_we   = req_fire && !is_first && !idx[0];
   assign store_addr = idx[STORE_AW:1] - STORE_AW'(1);

   // next state of the byte stage
   always_comb begin
      count_in     = count_ff;
      error_in     = error_ff;
      first_bad_in = first_bad_ff;
      pending_in   = pending_ff;
      if (req_fire) begin
         count_in     = is_last ? '0 : idx + INDEX_W'(1);
         error_in     = err_prior;
         first_bad_in = bad_prior;
         if (!good && !err_prior) begin
            error_in     = 1'b1;
            first_bad_in = idx;
         end
         if (idx[0]) begin
            pending_in = nib;
         end
      end
   end

   // frame complete flag, held until the result register takes it
   always_comb begin
      done_in = done_ff;
      fail_in = fail_ff;
      bad_in  = bad_ff;
      if (req_fire && is_last) begin
         done_in = 1'b1;
         fail_in = error_in;
         bad_in  = first_bad_in;
      end else if (out_load) begin
         done_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_ff && out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         error_ff     <= 1'b0;
         first_bad_ff <= '0;
         pending_ff   <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         error_ff     <= error_in;
         first_bad_ff <= first_bad_in;
         pending_ff   <= pending_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fail_ff <= fail_in;
      bad_ff  <= bad_in;
      if (store_we) begin
         store_ff[store_addr] <= {pending_ff, nib};
      end
      if (done_ff && out_load) begin
         rsp_ok_ff  <= !fail_ff;
         rsp_bad_ff <= fail_ff ? bad_ff : '0;
         rsp_disp_ff <= fail_ff ? '0 : display;
      end
   end

   mlcd_decode u_decode (
      .store   (store_ff),
      .display (display)
   );

   // result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_disp_ff.modifier,
                        rsp_disp_ff.coupling,
                        rsp_disp_ff.unit,
                        rsp_disp_ff.prefix,
                        rsp_disp_ff.negative,
                        rsp_disp_ff.point_flags,
                        rsp_disp_ff.digit_codes,
                        rsp_bad_ff};

endmodule

`default_nettype wire

@@ src/mlcd_checker.sv @@
`default_nettype none

module mlcd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a failure carries only the bad byte index
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[47:6] == '0)
      else $error("failure result has display fields");

   // a decoded frame reports no bad byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[5:0] == '0)
      else $error("decoded result has bad byte index");

   // bad byte index lies within the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] < 6'd35)
      else $error("bad byte index out of frame");

endmodule

bind meter_lcd_frame_decoder mlcd_checker u_mlcd_checker (.*);

`default_nettype wire
